### hw/rtl/num_pkg.sv
// Package for the non-uniform mutation block: widths, register indices, payload types
// and the fixed-point helpers shared by the configuration unit and the back end.
// Depends on nothing.
`default_nettype none

package num_pkg;

  localparam int VALUE_BITS    = 32;
  localparam int RAND_BITS     = 16;
  localparam int PROB_BITS     = 16;
  localparam int PERT_BITS     = 16;
  localparam int ITER_BITS     = 24;
  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 32;
  localparam int Q30_BITS      = 31;
  localparam int STEPS         = 16;
  localparam int QDEPTH        = 4;

  localparam logic [CFG_IDX_BITS-1:0] REG_PROB  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_PERT  = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_MAXIT = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_CURIT = CFG_IDX_BITS'(3);

  localparam logic [Q30_BITS-1:0] ONE30 = Q30_BITS'(1) << 30;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] gene_value;
    logic signed [VALUE_BITS-1:0] lower_limit;
    logic signed [VALUE_BITS-1:0] upper_limit;
    logic [RAND_BITS-1:0]         rand_apply;
    logic [RAND_BITS-1:0]         rand_direction;
    logic [RAND_BITS-1:0]         rand_step;
    logic [RAND_BITS-1:0]         rand_repair;
  } num_in_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] new_value;
    logic                         was_mutated;
  } num_out_t;

  // Classified request as held in the queue between front and back end.
  typedef struct packed {
    logic                         apply;
    logic signed [VALUE_BITS-1:0] val;
    logic signed [VALUE_BITS-1:0] lo;
    logic signed [VALUE_BITS-1:0] hi;
    logic                         neg;
    logic [VALUE_BITS:0]          ymag;
    logic signed [VALUE_BITS-1:0] half;
    logic [RAND_BITS-1:0]         rstep;
    logic [RAND_BITS-1:0]         rrep;
  } num_item_t;

  typedef struct packed {
    logic [PROB_BITS-1:0] prob;
    logic [PERT_BITS-1:0] pert;
    logic [Q30_BITS-1:0]  e;
    logic                 bsmall;
    logic                 ready;
  } num_cfg_t;

  typedef struct packed {
    logic [4:0]          n;
    logic [Q30_BITS-1:0] z;
  } num_norm_t;

  typedef struct packed {
    logic                hit;
    logic [Q30_BITS-1:0] z;
  } num_sq_t;

  function automatic logic [63:0] num_isqrt(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] bv;
    x  = v;
    r  = '0;
    bv = 64'h1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bv > x) bv = bv >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bv != '0) begin
        if (x >= r + bv) begin
          x = x - (r + bv);
          r = (r >> 1) + bv;
        end else begin
          r = r >> 1;
        end
        bv = bv >> 2;
      end
    end
    return r;
  endfunction

  // Factor 2^(-2^-j) in Q0.30, by repeated floor square roots from one half.
  function automatic logic [29:0] num_exp_factor(input int j);
    logic [63:0] c;
    c = 64'h1 << 29;
    for (int i = 1; i <= j; i++) begin
      c = num_isqrt(c << 30);
    end
    return c[29:0];
  endfunction

  localparam logic [29:0] EXP_C [STEPS] = '{
    num_exp_factor(1),  num_exp_factor(2),  num_exp_factor(3),  num_exp_factor(4),
    num_exp_factor(5),  num_exp_factor(6),  num_exp_factor(7),  num_exp_factor(8),
    num_exp_factor(9),  num_exp_factor(10), num_exp_factor(11), num_exp_factor(12),
    num_exp_factor(13), num_exp_factor(14), num_exp_factor(15), num_exp_factor(16)
  };

  // Leading-one position and the value normalised to Q1.30 (x is below 2^18).
  function automatic num_norm_t num_norm(input logic [31:0] x);
    num_norm_t   r;
    logic [62:0] w;
    r.n = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) r.n = 5'(i);
    end
    w   = {31'b0, x} << 30;
    r.z = Q30_BITS'(w >> r.n);
    return r;
  endfunction

  // One squaring step of the base-2 logarithm.
  function automatic num_sq_t num_square(input logic [Q30_BITS-1:0] z);
    logic [61:0] zz;
    num_sq_t     r;
    zz    = 62'(z) * 62'(z);
    r.hit = zz[61];
    r.z   = r.hit ? zz[61:31] : zz[60:30];
    return r;
  endfunction

  function automatic logic [Q30_BITS-1:0] num_exp_step(input logic [Q30_BITS-1:0] prod,
                                                       input logic [29:0] c);
    logic [60:0] p;
    p = 61'(prod) * 61'(c);
    return p[60:30];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/num_cfg.sv
// Configuration registers and the sequencer that derives e = t^b from them.
// Depends on num_pkg.
`default_nettype none

module num_cfg
  import num_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     valid,
  output logic                          ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  output num_cfg_t                      cfg
);

  localparam logic [2:0] SQ_IDLE = 3'd0;
  localparam logic [2:0] SQ_INIT = 3'd1;
  localparam logic [2:0] SQ_DIV  = 3'd2;
  localparam logic [2:0] SQ_NORM = 3'd3;
  localparam logic [2:0] SQ_LOG  = 3'd4;
  localparam logic [2:0] SQ_MUL  = 3'd5;
  localparam logic [2:0] SQ_EXP  = 3'd6;
  localparam logic [2:0] SQ_FIN  = 3'd7;

  logic [PROB_BITS-1:0] prob_r;
  logic [PERT_BITS-1:0] pert_r;
  logic [ITER_BITS-1:0] max_r, it_r;
  logic [2:0]           state_r, state_nxt;
  logic [4:0]           cnt_r, cnt_nxt;
  logic [ITER_BITS:0]   rem_r, rem_nxt;
  logic [16:0]          q_r, q_nxt;
  logic [Q30_BITS-1:0]  z_r, z_nxt;
  logic [15:0]          frac_r, frac_nxt;
  logic [4:0]           base_r, base_nxt;
  logic [27:0]          m_r, m_nxt;
  logic [Q30_BITS-1:0]  prod_r, prod_nxt;
  logic [Q30_BITS-1:0]  e_r, e_nxt;

  logic                 wr;
  logic [ITER_BITS-1:0] maxv, itc;
  logic                 ge;
  logic [ITER_BITS:0]   rsub;
  num_norm_t            nz;
  num_sq_t              sq;
  logic [20:0]          lval;
  logic [36:0]          mp;
  logic [11:0]          k;

  assign ready = 1'b1;
  assign wr    = valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prob_r <= '0;
      pert_r <= PERT_BITS'(1280);
      max_r  <= ITER_BITS'(25000);
      it_r   <= '0;
    end else if (wr) begin
      unique case (cfg_index)
        REG_PROB:  prob_r <= cfg_data[PROB_BITS-1:0];
        REG_PERT:  pert_r <= cfg_data[PERT_BITS-1:0];
        REG_MAXIT: max_r  <= cfg_data[ITER_BITS-1:0];
        REG_CURIT: it_r   <= cfg_data[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    maxv      = (max_r == '0) ? ITER_BITS'(1) : max_r;
    itc       = (it_r < maxv) ? it_r : maxv;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    z_nxt     = z_r;
    frac_nxt  = frac_r;
    base_nxt  = base_r;
    m_nxt     = m_r;
    prod_nxt  = prod_r;
    e_nxt     = e_r;
    ge        = rem_r >= {1'b0, maxv};
    rsub      = ge ? rem_r - {1'b0, maxv} : rem_r;
    nz        = num_norm(32'(q_r));
    sq        = num_square(z_r);
    lval      = {base_r, 16'b0} - {5'b0, frac_r};
    mp        = 37'(lval) * 37'(pert_r);
    k         = m_r[27:16];
    unique case (state_r)
      SQ_IDLE: ;
      SQ_INIT: begin
        rem_nxt   = {1'b0, maxv - itc};
        q_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = SQ_DIV;
      end
      SQ_DIV: begin
        // One quotient bit per cycle: integer bit first, then sixteen fraction bits.
        rem_nxt = {rsub[ITER_BITS-1:0], 1'b0};
        q_nxt   = {q_r[15:0], ge};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd16) state_nxt = SQ_NORM;
      end
      SQ_NORM: begin
        if (q_r == '0) begin
          e_nxt     = (pert_r != '0) ? '0 : ONE30;
          state_nxt = SQ_IDLE;
        end else begin
          z_nxt     = nz.z;
          base_nxt  = 5'd16 - nz.n;
          frac_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = SQ_LOG;
        end
      end
      SQ_LOG: begin
        z_nxt    = sq.z;
        frac_nxt = {frac_r[14:0], sq.hit};
        cnt_nxt  = cnt_r + 5'd1;
        if (cnt_r == 5'd15) state_nxt = SQ_MUL;
      end
      SQ_MUL: begin
        m_nxt     = mp[35:8];
        prod_nxt  = ONE30;
        cnt_nxt   = '0;
        state_nxt = SQ_EXP;
      end
      SQ_EXP: begin
        if (m_r[4'd15 - cnt_r[3:0]]) prod_nxt = num_exp_step(prod_r, EXP_C[cnt_r[3:0]]);
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd15) state_nxt = SQ_FIN;
      end
      SQ_FIN: begin
        e_nxt     = (k > 12'd30) ? '0 : (prod_r >> k[4:0]);
        state_nxt = SQ_IDLE;
      end
      default: state_nxt = SQ_IDLE;
    endcase
    // Any write restarts the derivation so that it always sees the newest registers.
    if (wr) state_nxt = SQ_INIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    z_r    <= z_nxt;
    frac_r <= frac_nxt;
    base_r <= base_nxt;
    m_r    <= m_nxt;
    prod_r <= prod_nxt;
    e_r    <= e_nxt;
  end

  always_comb begin
    cfg.prob   = prob_r;
    cfg.pert   = pert_r;
    cfg.e      = e_r;
    cfg.bsmall = (pert_r != '0) && (pert_r < PERT_BITS'(256));
    cfg.ready  = (state_r == SQ_IDLE);
  end

endmodule

`default_nettype wire

### hw/rtl/num_front.sv
// Front end: accepts gene requests, classifies them and holds them in a short queue.
// Depends on num_pkg.
`default_nettype none

module num_front
  import num_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  output logic           full,
  input  wire num_in_t   in_data,
  input  wire num_cfg_t  cfg,
  output num_item_t      q_head,
  output logic           q_empty,
  input  wire logic      q_pop
);

  localparam int V  = VALUE_BITS;
  localparam int PW = $clog2(QDEPTH);

  num_item_t           mem_r [QDEPTH];
  logic [PW-1:0]       wr_r, rd_r;
  logic [PW:0]         cnt_r, cnt_nxt;
  logic                acc;
  num_item_t           item;
  logic signed [V:0]   y, d;
  logic                dir_up;

  always_comb begin
    dir_up     = in_data.rand_direction <= (RAND_BITS'(1) << (RAND_BITS - 1));
    y          = dir_up ? ((V+1)'(in_data.upper_limit) - (V+1)'(in_data.gene_value))
                        : ((V+1)'(in_data.lower_limit) - (V+1)'(in_data.gene_value));
    d          = (V+1)'(in_data.upper_limit) - (V+1)'(in_data.lower_limit);
    item.apply = in_data.rand_apply < cfg.prob;
    item.val   = in_data.gene_value;
    item.lo    = in_data.lower_limit;
    item.hi    = in_data.upper_limit;
    item.neg   = y[V];
    item.ymag  = y[V] ? (V+1)'(-y) : (V+1)'(y);
    // Halving rounds toward zero, so negative differences are biased by one.
    item.half  = V'((d + $signed((V+1)'(d[V]))) >>> 1);
    item.rstep = in_data.rand_step;
    item.rrep  = in_data.rand_repair;
  end

  assign full    = (cnt_r == (PW+1)'(QDEPTH)) || !cfg.ready;
  assign acc     = push && !full;
  assign q_empty = (cnt_r == '0);
  assign q_head  = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (acc && !q_pop) cnt_nxt = cnt_r + (PW+1)'(1);
    else if (!acc && q_pop) cnt_nxt = cnt_r - (PW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (acc) wr_r <= wr_r + PW'(1);
      if (q_pop) rd_r <= rd_r + PW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) mem_r[wr_r] <= item;
  end

endmodule

`default_nettype wire

### hw/rtl/num_back.sv
// Back end: fixed pipeline for r^e, the step, repair and saturation, with the result register.
// Depends on num_pkg.
`default_nettype none

module num_back
  import num_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire num_cfg_t  cfg,
  input  wire num_item_t q_head,
  input  wire logic      q_empty,
  output logic           q_pop,
  output logic           empty,
  input  wire logic      pop,
  output num_out_t       out_data
);

  localparam int V   = VALUE_BITS;
  localparam int R   = RAND_BITS;
  localparam int P   = PERT_BITS;
  localparam int PRW = R + P;
  localparam int SPW = V + PRW + 1;
  localparam int SCW = SPW - 24;
  localparam int RW  = SCW + 1;
  localparam int DPW = V + 1 + Q30_BITS;

  localparam int SQ_LAST   = STEPS;
  localparam int ST_SPROD  = 1;
  localparam int ST_SCALE  = 2;
  localparam int ST_LOGM   = SQ_LAST + 1;
  localparam int EXP_FIRST = ST_LOGM + 1;
  localparam int EXP_LAST  = ST_LOGM + STEPS;
  localparam int ST_POW    = EXP_LAST + 1;
  localparam int ST_DELTA  = ST_POW + 1;
  localparam int ST_SUM    = ST_DELTA + 1;
  localparam int ST_SEL    = ST_SUM + 1;
  localparam int NST       = ST_SEL + 1;

  localparam logic signed [RW-1:0] SMAX = {{(RW-V+1){1'b0}}, {(V-1){1'b1}}};
  localparam logic signed [RW-1:0] SMIN = ~SMAX;

  typedef struct packed {
    logic                    apply;
    logic signed [V-1:0]     val;
    logic signed [V-1:0]     lo;
    logic signed [V-1:0]     hi;
    logic                    neg;
    logic [V:0]              ymag;
    logic signed [V-1:0]     half;
    logic                    rzero;
    logic [4:0]              base;
    logic [Q30_BITS-1:0]     z;
    logic [15:0]             frac;
    logic [PRW-1:0]          prand;
    logic signed [SPW-1:0]   sprod;
    logic signed [SCW-1:0]   scaled;
    logic [20:0]             m;
    logic [Q30_BITS-1:0]     prod;
    logic [Q30_BITS-1:0]     p;
    logic [V:0]              dmag;
    logic signed [V+1:0]     tmp;
    logic signed [RW-1:0]    clos;
    logic signed [RW-1:0]    cloh;
    logic signed [RW-1:0]    chis;
    logic signed [RW-1:0]    res;
  } num_pl_t;

  num_pl_t               st_r [NST];
  num_pl_t               st_nxt [NST];
  logic [NST-1:0]        v_r;
  logic                  adv;
  logic                  out_valid_r;
  num_out_t              out_r, out_nxt;

  num_norm_t             nz;
  num_sq_t               sq;
  logic [20:0]           lval;
  logic [51:0]           mp;
  logic [4:0]            k;
  logic [Q30_BITS-1:0]   pv;
  logic [DPW-1:0]        dp;
  logic signed [V+1:0]   dm;
  logic signed [SPW-1:0] sb;
  logic                  lt, gt;

  assign adv   = !(v_r[NST-1] && out_valid_r && !pop);
  assign q_pop = adv && !q_empty;
  assign empty = !out_valid_r;

  always_comb begin
    nz   = num_norm(32'(q_head.rstep));
    sq   = '0;
    lval = '0;
    mp   = '0;
    k    = '0;
    pv   = '0;
    dp   = '0;
    dm   = '0;
    sb   = '0;
    lt   = 1'b0;
    gt   = 1'b0;

    st_nxt[0]       = '0;
    st_nxt[0].apply = q_head.apply;
    st_nxt[0].val   = q_head.val;
    st_nxt[0].lo    = q_head.lo;
    st_nxt[0].hi    = q_head.hi;
    st_nxt[0].neg   = q_head.neg;
    st_nxt[0].ymag  = q_head.ymag;
    st_nxt[0].half  = q_head.half;
    st_nxt[0].rzero = (q_head.rstep == '0);
    st_nxt[0].base  = 5'(R) - nz.n;
    st_nxt[0].z     = nz.z;
    st_nxt[0].prand = PRW'(q_head.rrep) * PRW'(cfg.pert);

    for (int s = 1; s < NST; s++) begin
      st_nxt[s] = st_r[s-1];
      if (s <= SQ_LAST) begin
        sq             = num_square(st_r[s-1].z);
        st_nxt[s].z    = sq.z;
        st_nxt[s].frac = {st_r[s-1].frac[14:0], sq.hit};
      end
      if (s == ST_SPROD) begin
        st_nxt[s].sprod = SPW'(st_r[s-1].half) * $signed(SPW'(st_r[s-1].prand));
      end
      if (s == ST_SCALE) begin
        // Division by 2^24 rounds toward zero.
        sb = st_r[s-1].sprod + $signed(SPW'({24{st_r[s-1].sprod[SPW-1]}}));
        st_nxt[s].scaled = SCW'(sb >>> 24);
      end
      if (s == ST_LOGM) begin
        lval           = {st_r[s-1].base, 16'b0} - {5'b0, st_r[s-1].frac};
        mp             = 52'(lval) * 52'(cfg.e);
        st_nxt[s].m    = mp[50:30];
        st_nxt[s].prod = ONE30;
      end
      if (s >= EXP_FIRST && s <= EXP_LAST) begin
        if (st_r[s-1].m[EXP_LAST - s]) begin
          st_nxt[s].prod = num_exp_step(st_r[s-1].prod, EXP_C[s - EXP_FIRST]);
        end
      end
      if (s == ST_POW) begin
        k  = st_r[s-1].m[20:16];
        pv = (k > 5'd30) ? '0 : (st_r[s-1].prod >> k);
        if (st_r[s-1].rzero) st_nxt[s].p = (cfg.e != '0) ? '0 : ONE30;
        else st_nxt[s].p = pv;
      end
      if (s == ST_DELTA) begin
        dp             = DPW'(st_r[s-1].ymag) * DPW'(ONE30 - st_r[s-1].p);
        st_nxt[s].dmag = dp[V+30:30];
      end
      if (s == ST_SUM) begin
        dm             = $signed({1'b0, st_r[s-1].dmag});
        st_nxt[s].tmp  = (V+2)'(st_r[s-1].val) + (st_r[s-1].neg ? -dm : dm);
        st_nxt[s].clos = RW'(st_r[s-1].lo) + RW'(st_r[s-1].scaled);
        st_nxt[s].cloh = RW'(st_r[s-1].lo) + RW'(st_r[s-1].half);
        st_nxt[s].chis = RW'(st_r[s-1].hi) - RW'(st_r[s-1].scaled);
      end
      if (s == ST_SEL) begin
        lt = RW'(st_r[s-1].tmp) < RW'(st_r[s-1].lo);
        gt = RW'(st_r[s-1].tmp) > RW'(st_r[s-1].hi);
        priority if (lt) st_nxt[s].res = cfg.bsmall ? st_r[s-1].clos : st_r[s-1].cloh;
        else if (gt && cfg.bsmall) st_nxt[s].res = st_r[s-1].chis;
        else st_nxt[s].res = RW'(st_r[s-1].tmp);
      end
    end
  end

  always_comb begin
    out_nxt.was_mutated = st_r[NST-1].apply;
    if (!st_r[NST-1].apply) out_nxt.new_value = st_r[NST-1].val;
    else if (st_r[NST-1].res > SMAX) out_nxt.new_value = SMAX[V-1:0];
    else if (st_r[NST-1].res < SMIN) out_nxt.new_value = SMIN[V-1:0];
    else out_nxt.new_value = st_r[NST-1].res[V-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) v_r <= {v_r[NST-2:0], !q_empty};
      if (adv && v_r[NST-1]) out_valid_r <= 1'b1;
      else if (pop) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v_r[NST-1]) out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

### hw/rtl/non_uniform_mutation_top.sv
// Top level of the non-uniform mutation block: configuration unit, front end and back end.
// Depends on num_pkg, num_cfg, num_front and num_back.
`default_nettype none

// Channel   Ports                          Request moves when
// -------   -----------------------------  ------------------------
// input     push, full, in_data            push high and full low
// result    empty, pop, out_data           pop high and empty low
// config    valid, ready, cfg_index/data   valid and ready high
//
// One gene request is taken per clock while full is low; its result passes through the
// power pipeline (sixteen log squarings, sixteen exp2 products, then step, repair and
// saturation stages) and is held until popped. Reset is synchronous on rst_n.
// After reset and after every configuration write, full stays high while the sequencer
// derives t^b, one step a cycle; log and exp are skipped when the run has ended and t is zero.
// A result waiting on pop stalls the pipeline, but the four-entry queue keeps taking
// requests until it fills.

module non_uniform_mutation_top
  import num_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  output logic                          full,
  input  wire num_in_t                  in_data,
  output logic                          empty,
  input  wire logic                     pop,
  output num_out_t                      out_data,
  input  wire logic                     valid,
  output logic                          ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  num_cfg_t  cfg;
  num_item_t q_head;
  logic      q_empty;
  logic      q_pop;

  // Holds the registers and the exponent e derived from them.
  num_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid     (valid),
    .ready     (ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Classifies each request (apply, direction, distance, half range) into the queue.
  num_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .cfg     (cfg),
    .q_head  (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop)
  );

  // Carries out the arithmetic and presents results in order.
  num_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_head   (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

### tb/non_uniform_mutation_top_tb.sv
// Self-checking testbench for non_uniform_mutation_top: directed table, then random genes,
// checked against a behavioural predictor over several register settings.
// Depends on num_pkg and the non_uniform_mutation_top RTL.
`timescale 1ns / 1ps

module non_uniform_mutation_top_tb;
  import num_pkg::*;

  localparam longint unsigned Q30 = 64'h1 << 30;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_PER_PHASE = 185;

  logic                     clk;
  logic                     rst_n;
  logic                     push;
  logic                     full;
  num_in_t                  in_data;
  logic                     empty;
  logic                     pop;
  num_out_t                 out_data;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  non_uniform_mutation_top DUT (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data),
    .valid(valid), .ready(ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Outputs change only on the rising edge, so a copy taken at the falling edge is
  // exactly what the block presents at the next rising edge.
  logic     full_s, empty_s, ready_s;
  num_out_t out_s;
  always @(negedge clk) begin
    full_s  = full;
    empty_s = empty;
    ready_s = ready;
    out_s   = out_data;
  end

  // Shadow copy of the configuration registers.
  longint unsigned mut_prob, shape_b, iter_max, iter_now;

  num_out_t gene_expect_q[$];
  int       mismatches;
  int       genes_sent;
  int       cycle_count;

  // ---------------------------------------------------------------------------
  // Predictor of the mutation arithmetic.
  // ---------------------------------------------------------------------------

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned bt;
    r  = 0;
    bt = 64'h1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // -log2(x / 2^fbits) in Q.16, by normalising and repeated squaring.
  function automatic longint unsigned minus_log2(longint unsigned x, int fbits);
    int              lead;
    longint unsigned z;
    longint unsigned frac;
    lead = 0;
    frac = 0;
    while ((x >> lead) > 1) lead++;
    z = x << (30 - lead);
    for (int i = 0; i < 16; i++) begin
      z = (z * z) >> 30;
      if (z >= (Q30 << 1)) begin
        z = z >> 1;
        frac = frac | (64'h1 << (15 - i));
      end
    end
    return (longint'(fbits - lead) << 16) - frac;
  endfunction

  // 2^(-m / 65536) in Q0.30.
  function automatic longint unsigned pow2_minus(longint unsigned m);
    longint unsigned whole;
    longint unsigned prod;
    longint unsigned fac;
    whole = m >> 16;
    prod  = Q30;
    fac   = Q30 >> 1;
    if (whole > 30) return 0;
    for (int j = 1; j <= 16; j++) begin
      fac = floor_sqrt(fac << 30);
      if ((m >> (16 - j)) & 1) prod = (prod * fac) >> 30;
    end
    return prod >> whole;
  endfunction

  function automatic num_out_t predict_gene(num_in_t g);
    num_out_t        res;
    longint          val, lo, hi, y, delta, tmp, half;
    longint unsigned maxv, it, t, e, p, mag;
    bit              neg;
    val = longint'($signed(g.gene_value));
    lo  = longint'($signed(g.lower_limit));
    hi  = longint'($signed(g.upper_limit));
    if (!(longint'(g.rand_apply) < mut_prob)) begin
      res.new_value   = g.gene_value;
      res.was_mutated = 1'b0;
      return res;
    end
    // At or below one half the gene heads for the upper bound.
    y = (g.rand_direction <= 16'd32768) ? hi - val : lo - val;
    maxv = (iter_max != 0) ? iter_max : 1;
    it   = (iter_now < maxv) ? iter_now : maxv;
    t    = ((maxv - it) << 16) / maxv;
    if (t == 0) e = (shape_b != 0) ? 0 : Q30;
    else e = pow2_minus((minus_log2(t, 16) * shape_b) >> 8);
    if (g.rand_step == 0) p = (e != 0) ? 0 : Q30;
    else p = pow2_minus((minus_log2(longint'(g.rand_step), 16) * e) >> 30);
    neg   = y < 0;
    mag   = neg ? longint'(-y) : longint'(y);
    mag   = (mag * (Q30 - p)) >> 30;
    delta = neg ? -longint'(mag) : longint'(mag);
    tmp   = val + delta;
    half  = (hi - lo) / 2;
    if (tmp < lo) begin
      if (shape_b > 0 && shape_b < 256)
        tmp = lo + (half * longint'(g.rand_repair * shape_b)) / (longint'(1) << 24);
      else
        tmp = lo + half;
    end else if (tmp > hi) begin
      if (shape_b > 0 && shape_b < 256)
        tmp = hi - (half * longint'(g.rand_repair * shape_b)) / (longint'(1) << 24);
    end
    if (tmp > 64'sh7FFF_FFFF) tmp = 64'sh7FFF_FFFF;
    if (tmp < -64'sh8000_0000) tmp = -64'sh8000_0000;
    res.new_value   = tmp[31:0];
    res.was_mutated = 1'b1;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Rows with rand_apply at its maximum can never be mutated, so
  // their result is the gene itself and is typed in; every other row goes to the
  // predictor.
  // ---------------------------------------------------------------------------

  typedef struct {
    num_in_t  req;
    bit       known;
    num_out_t want;
  } gene_row_t;

  gene_row_t gene_table[$];

  function automatic gene_row_t make_row(logic [31:0] v, logic [31:0] lo, logic [31:0] hi,
                                         logic [15:0] ap, logic [15:0] dir,
                                         logic [15:0] stp, logic [15:0] rep);
    gene_row_t r;
    r.req  = '{v, lo, hi, ap, dir, stp, rep};
    r.known = (ap == 16'hFFFF);
    r.want = '{v, 1'b0};
    return r;
  endfunction

  initial begin
    // Pass-through rows at the extremes of every field.
    gene_table.push_back(make_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                  16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF));
    gene_table.push_back(make_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                  16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
    gene_table.push_back(make_row(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                  16'hFFFF, 16'h8000, 16'h5555, 16'hAAAA));
    gene_table.push_back(make_row(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                                  16'hFFFF, 16'h8001, 16'hAAAA, 16'h5555));
    // Direction on either side of one half.
    gene_table.push_back(make_row(32'h0001_0000, 32'hFFF6_0000, 32'h000A_0000,
                                  16'h0000, 16'h8000, 16'h4000, 16'h1234));
    gene_table.push_back(make_row(32'h0001_0000, 32'hFFF6_0000, 32'h000A_0000,
                                  16'h0000, 16'h8001, 16'h4000, 16'h1234));
    // Zero and full-scale random step.
    gene_table.push_back(make_row(32'h0000_8000, 32'h0000_0000, 32'h0010_0000,
                                  16'h0000, 16'h0000, 16'h0000, 16'h0000));
    gene_table.push_back(make_row(32'h0000_8000, 32'h0000_0000, 32'h0010_0000,
                                  16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // Gene below its lower bound with a small step up: repaired upward.
    gene_table.push_back(make_row(32'hFF00_0000, 32'h0000_0000, 32'h0100_0000,
                                  16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF));
    // Gene above its upper bound with a small step down: repaired or kept.
    gene_table.push_back(make_row(32'h0200_0000, 32'h0000_0000, 32'h0100_0000,
                                  16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000));
    // Inverted bounds and the widest range, where saturation can come into play.
    gene_table.push_back(make_row(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                  16'h0000, 16'h0000, 16'h0001, 16'hFFFF));
    gene_table.push_back(make_row(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                  16'h0000, 16'hFFFF, 16'h0001, 16'hFFFF));
    gene_table.push_back(make_row(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                  16'h0000, 16'h0000, 16'h0001, 16'h0000));
    gene_table.push_back(make_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                  16'h0000, 16'hFFFF, 16'h0001, 16'h0000));
    // Gene sitting exactly on a bound.
    gene_table.push_back(make_row(32'h0005_0000, 32'h0005_0000, 32'h0009_0000,
                                  16'hFFFE, 16'h7FFF, 16'h8000, 16'h0001));
  end

  // ---------------------------------------------------------------------------
  // Request side.
  // ---------------------------------------------------------------------------

  // Neither side idles while this stretch of genes is being sent.
  function automatic bit quiet_window();
    return (genes_sent >= 600) && (genes_sent < 800);
  endfunction

  function automatic bit sender_idles();
    if (quiet_window()) return 1'b0;
    return $urandom_range(0, 99) < 20;
  endfunction

  // Offers one gene and waits for the request to be taken. push is left high so
  // back-to-back genes need no second assignment in the same step.
  task automatic offer_gene(num_in_t g, bit known, num_out_t want);
    while (sender_idles()) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= g;
    do @(posedge clk); while (full_s);
    gene_expect_q.push_back(known ? want : predict_gene(g));
    genes_sent++;
  endtask

  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (gene_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, longint unsigned value);
    valid     <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_BITS-1:0];
    do @(posedge clk); while (!ready_s);
    valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_PROB:  mut_prob = value & 64'hFFFF;
      REG_PERT:  shape_b  = value & 64'hFFFF;
      REG_MAXIT: iter_max = value & 64'hFF_FFFF;
      REG_CURIT: iter_now = value & 64'hFF_FFFF;
      default: ;
    endcase
  endtask

  task automatic set_registers(longint unsigned prob, longint unsigned b,
                               longint unsigned mx, longint unsigned cur);
    write_register(REG_PROB, prob);
    write_register(REG_PERT, b);
    write_register(REG_MAXIT, mx);
    write_register(REG_CURIT, cur);
  endtask

  // Most genes are well formed: lower <= gene <= upper over a range of random width.
  // The rest are raw noise across the full width of every field.
  function automatic num_in_t random_gene();
    num_in_t g;
    longint  lo, hi, span;
    g = {$urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 99) < 80) begin
      lo   = longint'($signed($urandom)) >>> $urandom_range(0, 31);
      span = longint'($urandom >> $urandom_range(0, 31));
      hi   = lo + span;
      if (hi > 64'sh7FFF_FFFF) hi = 64'sh7FFF_FFFF;
      g.lower_limit = lo[31:0];
      g.upper_limit = hi[31:0];
      g.gene_value  = 32'(lo + longint'($urandom) % (hi - lo + 1));
    end
    case ($urandom_range(0, 5))
      0: g.rand_step = 16'h0000;
      1: g.rand_step = 16'hFFFF - 16'($urandom_range(0, 3));
      default: ;
    endcase
    if ($urandom_range(0, 5) == 0) g.rand_direction = 16'd32768 + 16'($urandom_range(0, 1));
    return g;
  endfunction

  task automatic run_phase(longint unsigned prob, longint unsigned b,
                           longint unsigned mx, longint unsigned cur);
    set_registers(prob, b, mx, cur);
    foreach (gene_table[i])
      offer_gene(gene_table[i].req, gene_table[i].known, gene_table[i].want);
    for (int n = 0; n < RANDOM_PER_PHASE; n++) offer_gene(random_gene(), 1'b0, '0);
    // The sender pauses here until every result is back, so the next writes find
    // the block idle.
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Result side.
  // ---------------------------------------------------------------------------

  int pop_hold_left;
  bit pop_hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      pop           <= 1'b0;
      pop_hold_left <= 0;
      pop_hold_done <= 1'b0;
    end else begin
      // A result is taken at this edge if we were popping and one was waiting.
      if (pop && !empty_s) begin
        if (gene_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: new_value=%0d was_mutated=%0b",
                     $signed(out_s.new_value), out_s.was_mutated);
        end else begin
          num_out_t want;
          want = gene_expect_q.pop_front();
          if (out_s.new_value !== want.new_value || out_s.was_mutated !== want.was_mutated)
          begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected new_value=%0d was_mutated=%0b, %s%0d %s%0b",
                       $signed(want.new_value), want.was_mutated, "got new_value=",
                       $signed(out_s.new_value), "was_mutated=", out_s.was_mutated);
          end
        end
      end
      // One long hold-off of the receiver, so the queue fills and full is seen.
      if (!pop_hold_done && genes_sent >= 300) begin
        pop_hold_done <= 1'b1;
        pop_hold_left <= 400;
        pop           <= 1'b0;
      end else if (pop_hold_left != 0) begin
        pop_hold_left <= pop_hold_left - 1;
        pop           <= 1'b0;
      end else if (quiet_window()) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(0, 99) >= 20);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Run control.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[non_uniform_mutation_top] ERROR");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    push        = 1'b0;
    in_data     = '0;
    valid       = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    mismatches  = 0;
    genes_sent  = 0;
    cycle_count = 0;
    mut_prob    = 0;
    shape_b     = 1280;
    iter_max    = 25000;
    iter_now    = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Straight after reset nothing is mutated, since the probability is zero.
    foreach (gene_table[i])
      offer_gene(gene_table[i].req, gene_table[i].known, gene_table[i].want);
    for (int n = 0; n < 40; n++) offer_gene(random_gene(), 1'b0, '0);
    drain_results();

    // Settings cover the register extremes: b small, b of zero, b at one, the
    // largest b, t of zero by a finished run, a count past its end, and the
    // smallest and largest iteration limits.
    run_phase(65535, 128, 100, 50);
    run_phase(65535, 0, 1, 0);
    run_phase(40000, 65535, 16777215, 16777215);
    run_phase(65535, 256, 1000, 2000);
    run_phase(65535, 255, 25000, 12345);
    run_phase(30000, 1280, 7, 3);
    run_phase(65535, 1, 16777215, 0);

    repeat (60) @(posedge clk);
    if (mismatches == 0 && gene_expect_q.size() == 0) begin
      $display("[non_uniform_mutation_top] OK");
    end else begin
      $display("[non_uniform_mutation_top] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/num_pkg.sv
hw/rtl/num_cfg.sv
hw/rtl/num_front.sv
hw/rtl/num_back.sv
hw/rtl/non_uniform_mutation_top.sv
tb/non_uniform_mutation_top_tb.sv
